/* design/rth_pkg.sv */
// Shared constants and types for the RGB to HSL converter.
package rth_pkg;

    localparam int ChanW        = 8;    // width of one color channel
    localparam int NumW         = 17;   // width of a raw numerator before scaling
    localparam int RemW         = 9;    // divider remainder and divisor width
    localparam int OutW         = 16;   // width of one result field
    localparam int FracBitsDflt = 8;    // default fraction bits of the results

    localparam int HueStep  = 40;       // one sixth of the 240 scale
    localparam int HueGreen = 80;       // hue offset, green is the maximum
    localparam int HueBlue  = 160;      // hue offset, blue is the maximum
    localparam int FullScl  = 240;      // full scale
    localparam int SumFold  = 510;      // twice the channel maximum

    // Control travelling alongside the divider payload
    typedef struct packed {
        logic valid;
        logic grey;     // max equals min: hue and saturation are zero
    } ctrl_t;

endpackage

/* design/rth_front.sv */
// Front stage: max/min search, numerator setup for the three lanes, divisor setup for hue and saturation.
module rth_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [rth_pkg::ChanW-1:0]       red,
    input  logic [rth_pkg::ChanW-1:0]       green,
    input  logic [rth_pkg::ChanW-1:0]       blue,
    output rth_pkg::ctrl_t                  ctrl_reg,
    output logic [rth_pkg::NumW-1:0]        hue_num_reg,
    output logic [rth_pkg::RemW-1:0]        hue_den_reg,
    output logic [rth_pkg::NumW-1:0]        sat_num_reg,
    output logic [rth_pkg::RemW-1:0]        sat_den_reg,
    output logic [rth_pkg::NumW-1:0]        lig_num_reg
);
    import rth_pkg::*;

    logic [ChanW-1:0] mx, mn, d;
    logic [RemW-1:0]  sum;
    logic             red_max, green_max;
    logic [NumW-1:0]  r17, g17, b17, d17, s17;
    ctrl_t            ctrl_next;
    logic [NumW-1:0]  hue_num_next, sat_num_next, lig_num_next;
    logic [RemW-1:0]  hue_den_next, sat_den_next;

    always_comb
    begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        mx = red_max ? red : (green_max ? green : blue);
        mn = (red <= green) ? red : green;
        if (blue < mn)
        begin
            mn = blue;
        end
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};

        r17 = NumW'(red);
        g17 = NumW'(green);
        b17 = NumW'(blue);
        d17 = NumW'(d);
        s17 = NumW'(sum);

        // modular arithmetic in NumW bits; every final value is non-negative
        if (red_max)
        begin
            if (green >= blue)
            begin
                hue_num_next = NumW'(HueStep) * (g17 - b17);
            end
            else
            begin
                hue_num_next = NumW'(FullScl) * d17 - NumW'(HueStep) * (b17 - g17);
            end
        end
        else if (green_max)
        begin
            hue_num_next = NumW'(HueGreen) * d17 + NumW'(HueStep) * b17
                         - NumW'(HueStep) * r17;
        end
        else
        begin
            hue_num_next = NumW'(HueBlue) * d17 + NumW'(HueStep) * r17
                         - NumW'(HueStep) * g17;
        end
        hue_den_next = {1'b0, d};

        sat_num_next = NumW'(FullScl) * d17;
        sat_den_next = (sum <= RemW'(255)) ? sum : RemW'(SumFold) - sum;

        lig_num_next = NumW'(FullScl) * s17;

        ctrl_next.valid = in_valid;
        ctrl_next.grey  = (d == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_num_reg <= hue_num_next;
            hue_den_reg <= hue_den_next;
            sat_num_reg <= sat_num_next;
            sat_den_reg <= sat_den_next;
            lig_num_reg <= lig_num_next;
        end
    end

endmodule

/* design/rth_div_cell.sv */
// One restoring-division cell: resolves one quotient bit and passes it on.
module rth_div_cell #(
    parameter int QuotW = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [rth_pkg::RemW-1:0]    rem_in,
    input  logic [rth_pkg::RemW-1:0]    den_in,
    input  logic [QuotW-1:0]            word_in,
    output logic [rth_pkg::RemW-1:0]    rem_reg,
    output logic [rth_pkg::RemW-1:0]    den_reg,
    output logic [QuotW-1:0]            word_reg
);
    import rth_pkg::*;

    logic [RemW:0]   trial;
    logic            fits;
    logic [RemW-1:0] rem_next;
    logic [QuotW-1:0] word_next;

    // word: dividend bits still to bring down at the top, quotient bits at the bottom
    always_comb
    begin
        trial     = {rem_in, word_in[QuotW-1]};
        fits      = (trial >= {1'b0, den_in});
        rem_next  = fits ? RemW'(trial - {1'b0, den_in}) : RemW'(trial);
        word_next = {word_in[QuotW-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            word_reg <= word_next;
        end
    end

endmodule

/* design/rgb_to_hsl_converter.sv */
// Top level: RGB pixel stream in, HSL (0..240 scale, fixed point) stream out.
//
// Usage:
//   Slave channel s_*: one pixel per transaction, s_tdata = red, green, blue.
//   Master channel m_*: one result per transaction, m_tdata = hue, saturation,
//   lightness, each unsigned with FRAC_BITS fraction bits, truncated and
//   kept to 16 bits.
//   Pipeline from an accepted pixel to m_tvalid: front stage,
//   8 + FRAC_BITS divider cells, output register.
//   Throughput: one pixel per clock while the output does not stall. The row
//   of divider cells resolves one quotient bit per cell, three lanes side by
//   side (hue, saturation, lightness), so a new pixel enters every cycle without a stall.
//   Stall: when the receiver holds m_tready low with a result waiting, the
//   whole pipeline freezes and s_tready drops in the same cycle; nothing is
//   lost or repeated.
//   Reset: rst_n clears all valid flags; no results are pending afterwards.
//   Grey pixels (max equals min) give hue and saturation of zero.
module rgb_to_hsl_converter #(
    parameter int FRAC_BITS = rth_pkg::FracBitsDflt
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // [15:0] hue, [31:16] saturation, [47:32] lightness
);
    import rth_pkg::*;

    // quotients stay at or below 240 << FRAC_BITS
    localparam int QuotW  = ChanW + FRAC_BITS;
    localparam int Cells  = QuotW;
    localparam int Lanes  = 3;
    localparam int LnHue  = 0;
    localparam int LnSat  = 1;
    localparam int LnLig  = 2;

    logic en;

    ctrl_t           front_ctrl;
    logic [NumW-1:0] hue_num, sat_num, lig_num;
    logic [RemW-1:0] hue_den, sat_den;

    // stage k feeds cell k; stage Cells is the last cell output
    logic [RemW-1:0]  rem_s  [Lanes][Cells+1];
    logic [RemW-1:0]  den_s  [Lanes][Cells+1];
    logic [QuotW-1:0] word_s [Lanes][Cells+1];
    ctrl_t            ctrl_s [Cells+1];

    logic            m_tvalid_reg;
    logic [OutW-1:0] hue_reg, sat_reg, lig_reg;
    logic [NumW-1:0] lane_num [Lanes];
    logic [RemW-1:0] lane_den [Lanes];

    // pipeline moves whenever the output register is free or being emptied
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    rth_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_tvalid),
        .red         (s_tdata[7:0]),
        .green       (s_tdata[15:8]),
        .blue        (s_tdata[23:16]),
        .ctrl_reg    (front_ctrl),
        .hue_num_reg (hue_num),
        .hue_den_reg (hue_den),
        .sat_num_reg (sat_num),
        .sat_den_reg (sat_den),
        .lig_num_reg (lig_num)
    );

    assign lane_num[LnHue] = hue_num;
    assign lane_num[LnSat] = sat_num;
    assign lane_num[LnLig] = lig_num;
    assign lane_den[LnHue] = hue_den;
    assign lane_den[LnSat] = sat_den;
    assign lane_den[LnLig] = RemW'(SumFold);

    assign ctrl_s[0] = front_ctrl;

    // dividend is num << FRAC_BITS; its bits above QuotW seed the remainder
    genvar ln, ck;
    generate
        for (ln = 0; ln < Lanes; ln++)
        begin : g_lane
            assign rem_s[ln][0]  = lane_num[ln][NumW-1:ChanW];
            assign den_s[ln][0]  = lane_den[ln];
            assign word_s[ln][0] = QuotW'(lane_num[ln][ChanW-1:0]) << FRAC_BITS;

            for (ck = 0; ck < Cells; ck++)
            begin : g_cell
                rth_div_cell #(
                    .QuotW (QuotW)
                ) u_cell (
                    .clk      (clk),
                    .en       (en),
                    .rem_in   (rem_s[ln][ck]),
                    .den_in   (den_s[ln][ck]),
                    .word_in  (word_s[ln][ck]),
                    .rem_reg  (rem_s[ln][ck+1]),
                    .den_reg  (den_s[ln][ck+1]),
                    .word_reg (word_s[ln][ck+1])
                );
            end
        end

        // control flags ride along with the cells
        for (ck = 0; ck < Cells; ck++)
        begin : g_ctrl
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ctrl_s[ck+1] <= '0;
                end
                else if (en)
                begin
                    ctrl_s[ck+1] <= ctrl_s[ck];
                end
            end
        end
    endgenerate

    // output register; grey pixels force hue and saturation to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= ctrl_s[Cells].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg <= ctrl_s[Cells].grey ? '0 : OutW'(word_s[LnHue][Cells]);
            sat_reg <= ctrl_s[Cells].grey ? '0 : OutW'(word_s[LnSat][Cells]);
            lig_reg <= OutW'(word_s[LnLig][Cells]);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {lig_reg, sat_reg, hue_reg};

    // an accepted pixel shows up in the front stage next cycle
    a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ctrl_s[0].valid)
        else $error("accepted pixel did not enter the front stage");

    // a stalled pipeline keeps its last cell and output in place
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(ctrl_s[Cells]) && $stable(m_tvalid_reg))
        else $error("pipeline moved during a stall");

    // a valid last cell with no stall must produce a result next cycle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        en && ctrl_s[Cells].valid |=> m_tvalid)
        else $error("result from the last cell was dropped");

    // a waiting, untaken result blocks input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output is stalled");

endmodule

/* test/tb_top.sv */
// Testbench for rgb_to_hsl_converter: random pixel stream checked against an in-bench HSL model.
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC_BITS       = 8;
    localparam int NUM_RANDOM      = 1650;
    localparam int DRAIN_EVERY     = 400;   // sender waits for an empty pipe this often
    localparam int LONG_HOLD_AT    = 500;   // results between long receiver hold-offs
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int NUM_LONG_HOLDS  = 2;
    localparam int TAIL_CYCLES     = FRAC_BITS + 30;

    // Pixel classes for the random part
    localparam int CLS_UNIFORM  = 0;
    localparam int CLS_TIE      = 1;
    localparam int CLS_GREY     = 2;
    localparam int CLS_EXTREME  = 3;
    localparam int CLS_BOUNDARY = 4;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        int unsigned idle_before;
        bit          drain;
    } pixel_t;

    typedef struct {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [15:0] lightness;
    } hsl_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    pixel_t      pixel_queue[$];
    hsl_t        hsl_expected[$];
    int unsigned pixels_total  = 0;
    int unsigned pixels_sent   = 0;
    int unsigned results_seen  = 0;
    int unsigned fail_count    = 0;
    bit          in_taken      = 1'b0;  // the offer seen at the last rising edge went through
    bit          quiet_segment = 1'b0;  // current stretch of stimulus has no sender idles
    bit          long_hold     = 1'b0;  // receiver is in a long hold-off
    int unsigned idle_cnt      = 0;
    int unsigned rx_hold       = 0;
    int unsigned rx_calm       = 0;
    int unsigned long_hold_left = 0;
    int unsigned long_holds_done = 0;

    rgb_to_hsl_converter #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Truncated fixed-point quotient
    function automatic longint unsigned frac_div(input longint unsigned num,
                                                 input longint unsigned den);
        if (den == 0)
            return 0;
        return (num << FRAC_BITS) / den;
    endfunction

    function automatic hsl_t hsl_of(input logic [7:0] red, input logic [7:0] green,
                                    input logic [7:0] blue);
        longint unsigned r, g, b, mx, mn, d, sum, h, s, l;
        hsl_t res;
        r = red;
        g = green;
        b = blue;
        mx = (r >= g) ? r : g;
        if (b > mx)
            mx = b;
        mn = (r <= g) ? r : g;
        if (b < mn)
            mn = b;
        d = mx - mn;
        sum = mx + mn;

        // offsets times d keep every numerator non-negative
        if (d == 0)
            h = 0;
        else if (r == mx)
            h = (g >= b) ? frac_div(40 * (g - b), d) : frac_div(240 * d - 40 * (b - g), d);
        else if (g == mx)
            h = frac_div(80 * d + 40 * b - 40 * r, d);
        else
            h = frac_div(160 * d + 40 * r - 40 * g, d);

        if (d == 0)
            s = 0;
        else if (sum <= 255)
            s = frac_div(240 * d, sum);
        else
            s = frac_div(240 * d, 510 - sum);

        l = frac_div(240 * sum, 510);

        res.hue        = h[15:0];
        res.saturation = s[15:0];
        res.lightness  = l[15:0];
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_idle();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        else if (p < 85)
            return $urandom_range(1, 3);
        else if (p < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic add_pixel(input int red, input int green, input int blue, input bit drain);
        pixel_t px;
        px.red         = red[7:0];
        px.green       = green[7:0];
        px.blue        = blue[7:0];
        px.idle_before = quiet_segment ? 0 : pick_idle();
        px.drain       = drain;
        pixel_queue.push_back(px);
        pixels_total++;
    endtask

    // Sender: offers the head of the queue, holds it until taken
    always @(negedge clk)
    begin : pixel_driver
        pixel_t cur;
        if (rst_n && (!s_tvalid || in_taken)) begin
            if (pixel_queue.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (!long_hold && idle_cnt < pixel_queue[0].idle_before) begin
                idle_cnt++;
                s_tvalid <= 1'b0;
            end else if (pixel_queue[0].drain && hsl_expected.size() != 0) begin
                s_tvalid <= 1'b0;
            end else begin
                cur = pixel_queue.pop_front();
                s_tdata  <= {cur.blue, cur.green, cur.red};
                s_tvalid <= 1'b1;
                idle_cnt = 0;
            end
        end
    end

    // Receiver: random stalls, calm stretches, and a few long hold-offs
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (long_hold_left > 0) begin
                long_hold_left--;
                m_tready <= 1'b0;
                long_hold <= 1'b1;
            end else if (long_holds_done < NUM_LONG_HOLDS &&
                         results_seen >= (long_holds_done + 1) * LONG_HOLD_AT) begin
                long_hold_left = LONG_HOLD_CYCLES - 1;
                long_holds_done++;
                m_tready <= 1'b0;
                long_hold <= 1'b1;
            end else if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
                long_hold <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                long_hold <= 1'b0;
                if (rx_calm > 0)
                    rx_calm--;
                else if ($urandom_range(0, 199) == 0)
                    rx_calm = $urandom_range(50, 150);
                else if ($urandom_range(0, 99) < 30)
                    rx_hold = pick_idle();
            end
        end
    end

    // Both channels sampled at the rising edge
    always @(posedge clk)
    begin : hsl_monitor
        hsl_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (hsl_expected.size() == 0) begin
                    $error("result with no pending pixel: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = hsl_expected.pop_front();
                    if (m_tdata[15:0] !== want.hue) begin
                        $error("hue mismatch: expected %0d, actual %0d", want.hue, m_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_tdata[31:16] !== want.saturation) begin
                        $error("saturation mismatch: expected %0d, actual %0d",
                               want.saturation, m_tdata[31:16]);
                        fail_count++;
                    end
                    if (m_tdata[47:32] !== want.lightness) begin
                        $error("lightness mismatch: expected %0d, actual %0d",
                               want.lightness, m_tdata[47:32]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                hsl_expected.push_back(hsl_of(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
                pixels_sent++;
            end
        end
        in_taken <= s_tvalid && s_tready;
    end

    initial
    begin : stimulus
        int cls, perm, lo, mid, hi, v;

        // corners: black, white, primaries, ties for the maximum, grey
        add_pixel(0, 0, 0, 1'b0);
        add_pixel(255, 255, 255, 1'b0);
        add_pixel(255, 0, 0, 1'b0);
        add_pixel(0, 255, 0, 1'b0);
        add_pixel(0, 0, 255, 1'b0);
        add_pixel(255, 255, 0, 1'b0);   // red and green tie
        add_pixel(0, 255, 255, 1'b0);   // green and blue tie
        add_pixel(255, 0, 255, 1'b0);   // red and blue tie, green below blue
        add_pixel(128, 128, 128, 1'b0);
        add_pixel(90, 90, 90, 1'b0);
        add_pixel(1, 0, 0, 1'b0);
        add_pixel(0, 0, 1, 1'b0);
        add_pixel(200, 55, 100, 1'b0);  // max + min exactly 255
        add_pixel(200, 56, 100, 1'b0);  // max + min just above 255
        add_pixel(255, 0, 1, 1'b0);     // red max, green below blue
        add_pixel(254, 255, 0, 1'b0);
        add_pixel(0, 1, 255, 1'b0);
        add_pixel(170, 85, 0, 1'b0);
        add_pixel(255, 254, 254, 1'b0);
        add_pixel(1, 1, 0, 1'b0);
        add_pixel(170, 85, 170, 1'b0);
        add_pixel(85, 170, 85, 1'b0);
        add_pixel(127, 128, 0, 1'b0);
        add_pixel(0, 127, 254, 1'b0);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 100 == 0)
                quiet_segment = ($urandom_range(0, 3) == 0);
            v = $urandom_range(0, 99);
            if (v < 55)
                cls = CLS_UNIFORM;
            else if (v < 72)
                cls = CLS_TIE;
            else if (v < 80)
                cls = CLS_GREY;
            else if (v < 90)
                cls = CLS_EXTREME;
            else
                cls = CLS_BOUNDARY;

            case (cls)
                CLS_UNIFORM: begin
                    lo  = $urandom_range(0, 255);
                    mid = $urandom_range(0, 255);
                    hi  = $urandom_range(0, 255);
                end
                CLS_TIE: begin
                    lo  = $urandom_range(0, 255);
                    mid = $urandom_range(0, 255);
                    hi  = mid;
                end
                CLS_GREY: begin
                    lo  = $urandom_range(0, 255);
                    mid = lo;
                    hi  = lo;
                end
                CLS_EXTREME: begin
                    lo  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : $urandom_range(254, 255);
                    mid = ($urandom_range(0, 1) == 1) ? $urandom_range(127, 128) : $urandom_range(0, 255);
                    hi  = ($urandom_range(0, 1) == 1) ? $urandom_range(254, 255) : $urandom_range(0, 1);
                end
                default: begin
                    // max + min within one of 255
                    hi  = $urandom_range(128, 254);
                    lo  = 254 - hi + $urandom_range(0, 2);
                    mid = $urandom_range(lo, hi);
                end
            endcase

            perm = $urandom_range(0, 5);
            case (perm)
                0: add_pixel(hi, mid, lo, (i % DRAIN_EVERY) == 0);
                1: add_pixel(hi, lo, mid, (i % DRAIN_EVERY) == 0);
                2: add_pixel(mid, hi, lo, (i % DRAIN_EVERY) == 0);
                3: add_pixel(lo, hi, mid, (i % DRAIN_EVERY) == 0);
                4: add_pixel(mid, lo, hi, (i % DRAIN_EVERY) == 0);
                default: add_pixel(lo, mid, hi, (i % DRAIN_EVERY) == 0);
            endcase
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pixels_sent != pixels_total || hsl_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
design/rth_pkg.sv
design/rth_front.sv
design/rth_div_cell.sv
design/rgb_to_hsl_converter.sv
test/tb_top.sv
